### design/hhst_pkg.sv
`default_nettype none
package hhst_pkg;
    localparam int MAX_SOURCES = 64;
    localparam int MAX_PAIRS = 256;
    localparam int MAX_PORT_ENTRIES = 1024;
    localparam int SW = $clog2(MAX_SOURCES);
    localparam int PW = $clog2(MAX_PAIRS);
    localparam int QW = $clog2(MAX_PORT_ENTRIES);
    localparam logic [15:0] NO_PORT = 16'hFFFF;
    localparam logic [10:0] COUNT_MAX = 11'd2047;

    localparam logic [1:0] OVF_NONE = 2'd0;
    localparam logic [1:0] OVF_SRC = 2'd1;
    localparam logic [1:0] OVF_PAIR = 2'd2;
    localparam logic [1:0] OVF_PORT = 2'd3;

    localparam logic CFG_HEAVY = 1'b0;
    localparam logic CFG_SCAN = 1'b1;

    typedef enum logic [8:0] {
        ST_IDLE  = 9'b000000001,
        ST_SSCAN = 9'b000000010,
        ST_SUPD  = 9'b000000100,
        ST_PSCAN = 9'b000001000,
        ST_PRD   = 9'b000010000,
        ST_QSCAN = 9'b000100000,
        ST_QUPD  = 9'b001000000,
        ST_WB    = 9'b010000000,
        ST_OUT   = 9'b100000000
    } state_t;
endpackage
`default_nettype wire

### design/heavy_hitter_scan_tracker.sv
`default_nettype none
// Heavy-hitter and vertical port-scan tracker. One packet summary is taken per
// transaction and yields exactly one result transaction. A single sequencer
// walks the source table, then the pair table, then the port store. It reads
// one entry per cycle through one registered read port per table and uses one
// shared equality compare per table. With S, P and Q the current fill counts
// (at most 64, 256 and 1024), a miss-everywhere item walks all S + P + Q
// entries before its result shows. s_tready returns in the cycle after the
// result is taken; the tracker takes no new item before it is done with the
// last one. Hits end a scan early. A dest_port of 65535 skips the port
// store. s_tready is low while an item is in progress. new_epoch empties the
// tables by resetting the fill counts; no clearing pass is needed.
// Configuration writes: index 0 heavy_threshold, index 1 scan_threshold.
module heavy_hitter_scan_tracker (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // source_address[31:0], dest_address[63:32], dest_port[79:64],
    // packet_length[95:80], time_ticks[127:96]
    input  wire logic [127:0] s_tdata,
    // new_epoch[0]
    input  wire logic         s_tuser,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // source_total[31:0], heavy_flag[32], heavy_time[64:33],
    // distinct_ports[75:65], scan_flag[76], scan_time[108:77],
    // overflow_code[110:109], zero[111]
    output logic [111:0]      m_tdata,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [0:0]   cfg_index,
    input  wire logic [31:0]  cfg_data
);
    localparam int SW = hhst_pkg::SW;
    localparam int PW = hhst_pkg::PW;
    localparam int QW = hhst_pkg::QW;

    // tables
    logic [31:0] s_addr_mem  [hhst_pkg::MAX_SOURCES];
    logic [31:0] s_tot_mem   [hhst_pkg::MAX_SOURCES];
    logic        s_mark_mem  [hhst_pkg::MAX_SOURCES];
    logic [31:0] s_stamp_mem [hhst_pkg::MAX_SOURCES];
    logic [SW-1:0] p_own_mem [hhst_pkg::MAX_PAIRS];
    logic [31:0] p_dst_mem   [hhst_pkg::MAX_PAIRS];
    logic [10:0] p_cnt_mem   [hhst_pkg::MAX_PAIRS];
    logic        p_mark_mem  [hhst_pkg::MAX_PAIRS];
    logic [31:0] p_stamp_mem [hhst_pkg::MAX_PAIRS];
    logic [PW-1:0] q_own_mem [hhst_pkg::MAX_PORT_ENTRIES];
    logic [15:0] q_val_mem   [hhst_pkg::MAX_PORT_ENTRIES];

    hhst_pkg::state_t state_reg;
    logic [31:0] heavy_thr_reg;
    logic [15:0] scan_thr_reg;
    logic [SW:0] s_fill_reg;
    logic [PW:0] p_fill_reg;
    logic [QW:0] q_fill_reg;

    logic [31:0] src_reg, dst_reg, now_reg;
    logic [15:0] port_reg, len_reg;
    logic [QW:0] idx_reg;        // scan position, wide enough for any table
    logic        rd_ok_reg;      // read data valid for previous idx
    logic [SW-1:0] s_idx_reg;
    logic [PW-1:0] p_idx_reg;
    logic        hit_reg;

    // registered read data, all for the entry at rd_idx_prev_reg
    logic [31:0] s_addr_rd, p_dst_rd;
    logic [31:0] s_tot_rd, s_stamp_rd, p_stamp_rd;
    logic        s_mark_rd, p_mark_rd;
    logic [10:0] p_cnt_rd;
    logic [SW-1:0] p_own_rd;
    logic [PW-1:0] q_own_rd;
    logic [15:0] q_val_rd;

    logic [31:0] tot_reg, hstamp_reg, pstamp_reg;
    logic        hmark_reg, pmark_reg;
    logic [10:0] cnt_reg;
    logic [1:0]  ovf_reg;
    logic [QW:0] rd_idx_prev_reg;

    assign s_tready = (state_reg == hhst_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid = (state_reg == hhst_pkg::ST_OUT);
    assign m_tdata = {1'b0, ovf_reg, pstamp_reg, pmark_reg, cnt_reg,
                      hstamp_reg, hmark_reg, tot_reg};

    // tot_reg holds the stored total of the matched source during ST_SUPD
    logic [32:0] sum;
    assign sum = {1'b0, tot_reg} + {17'd0, len_reg};

    always_ff @(posedge aclk) begin
        s_addr_rd  <= s_addr_mem[idx_reg[SW-1:0]];
        s_tot_rd   <= s_tot_mem[idx_reg[SW-1:0]];
        s_mark_rd  <= s_mark_mem[idx_reg[SW-1:0]];
        s_stamp_rd <= s_stamp_mem[idx_reg[SW-1:0]];
        p_dst_rd   <= p_dst_mem[idx_reg[PW-1:0]];
        p_own_rd   <= p_own_mem[idx_reg[PW-1:0]];
        p_cnt_rd   <= p_cnt_mem[idx_reg[PW-1:0]];
        p_mark_rd  <= p_mark_mem[idx_reg[PW-1:0]];
        p_stamp_rd <= p_stamp_mem[idx_reg[PW-1:0]];
        q_own_rd   <= q_own_mem[idx_reg[QW-1:0]];
        q_val_rd   <= q_val_mem[idx_reg[QW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= hhst_pkg::ST_IDLE;
            heavy_thr_reg <= '1;
            scan_thr_reg <= '1;
            s_fill_reg <= '0;
            p_fill_reg <= '0;
            q_fill_reg <= '0;
            rd_ok_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index[0])
                    hhst_pkg::CFG_HEAVY: heavy_thr_reg <= cfg_data;
                    hhst_pkg::CFG_SCAN:  scan_thr_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end
            unique case (state_reg)
                hhst_pkg::ST_IDLE: begin
                    if (s_tvalid) begin
                        src_reg  <= s_tdata[31:0];
                        dst_reg  <= s_tdata[63:32];
                        port_reg <= s_tdata[79:64];
                        len_reg  <= s_tdata[95:80];
                        now_reg  <= s_tdata[127:96];
                        if (s_tuser) begin
                            s_fill_reg <= '0;
                            p_fill_reg <= '0;
                            q_fill_reg <= '0;
                        end
                        idx_reg <= '0;
                        rd_ok_reg <= 1'b0;
                        rd_idx_prev_reg <= '0;
                        hit_reg <= 1'b0;
                        ovf_reg <= hhst_pkg::OVF_NONE;
                        state_reg <= hhst_pkg::ST_SSCAN;
                    end
                end
                hhst_pkg::ST_SSCAN: begin
                    // compare previous read, advance address
                    if (rd_ok_reg && s_addr_rd == src_reg) begin
                        hit_reg <= 1'b1;
                        s_idx_reg <= rd_idx_prev_reg[SW-1:0];
                        tot_reg <= s_tot_rd;
                        hmark_reg <= s_mark_rd;
                        hstamp_reg <= s_stamp_rd;
                        state_reg <= hhst_pkg::ST_SUPD;
                    end else if (idx_reg >= (QW+1)'(s_fill_reg) && !rd_ok_reg) begin
                        if (s_fill_reg >= (SW+1)'(hhst_pkg::MAX_SOURCES)) begin
                            ovf_reg <= hhst_pkg::OVF_SRC;
                            tot_reg <= '0; hmark_reg <= 1'b0; hstamp_reg <= '0;
                            cnt_reg <= '0; pmark_reg <= 1'b0; pstamp_reg <= '0;
                            state_reg <= hhst_pkg::ST_OUT;
                        end else begin
                            s_idx_reg <= s_fill_reg[SW-1:0];
                            s_fill_reg <= s_fill_reg + 1'b1;
                            state_reg <= hhst_pkg::ST_SUPD;
                        end
                    end else begin
                        rd_idx_prev_reg <= idx_reg;
                        rd_ok_reg <= (idx_reg < (QW+1)'(s_fill_reg));
                        if (idx_reg < (QW+1)'(s_fill_reg)) idx_reg <= idx_reg + 1'b1;
                    end
                end
                hhst_pkg::ST_SUPD: begin
                    logic [31:0] t;
                    logic m;
                    logic [31:0] st;
                    if (hit_reg) begin
                        t = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
                        m = hmark_reg;
                        st = hstamp_reg;
                    end else begin
                        t = {16'd0, len_reg};
                        m = 1'b0;
                        st = '0;
                    end
                    if (t >= heavy_thr_reg && !m) begin
                        m = 1'b1;
                        st = now_reg;
                    end
                    s_addr_mem[s_idx_reg] <= src_reg;
                    s_tot_mem[s_idx_reg] <= t;
                    s_mark_mem[s_idx_reg] <= m;
                    s_stamp_mem[s_idx_reg] <= st;
                    tot_reg <= t; hmark_reg <= m; hstamp_reg <= st;
                    idx_reg <= '0; rd_ok_reg <= 1'b0; hit_reg <= 1'b0;
                    state_reg <= hhst_pkg::ST_PSCAN;
                end
                hhst_pkg::ST_PSCAN: begin
                    if (rd_ok_reg && p_own_rd == s_idx_reg && p_dst_rd == dst_reg) begin
                        hit_reg <= 1'b1;
                        p_idx_reg <= rd_idx_prev_reg[PW-1:0];
                        cnt_reg <= p_cnt_rd;
                        pmark_reg <= p_mark_rd;
                        pstamp_reg <= p_stamp_rd;
                        state_reg <= hhst_pkg::ST_PRD;
                    end else if (idx_reg >= (QW+1)'(p_fill_reg) && !rd_ok_reg) begin
                        if (p_fill_reg >= (PW+1)'(hhst_pkg::MAX_PAIRS)) begin
                            ovf_reg <= hhst_pkg::OVF_PAIR;
                            cnt_reg <= '0; pmark_reg <= 1'b0; pstamp_reg <= '0;
                            state_reg <= hhst_pkg::ST_OUT;
                        end else begin
                            p_idx_reg <= p_fill_reg[PW-1:0];
                            p_fill_reg <= p_fill_reg + 1'b1;
                            state_reg <= hhst_pkg::ST_PRD;
                        end
                    end else begin
                        rd_idx_prev_reg <= idx_reg;
                        rd_ok_reg <= (idx_reg < (QW+1)'(p_fill_reg));
                        if (idx_reg < (QW+1)'(p_fill_reg)) idx_reg <= idx_reg + 1'b1;
                    end
                end
                hhst_pkg::ST_PRD: begin
                    // a found pair already holds its stored fields
                    if (!hit_reg) begin
                        cnt_reg <= '0; pmark_reg <= 1'b0; pstamp_reg <= '0;
                    end
                    idx_reg <= '0; rd_ok_reg <= 1'b0; hit_reg <= 1'b0;
                    state_reg <= (port_reg == hhst_pkg::NO_PORT) ?
                                 hhst_pkg::ST_WB : hhst_pkg::ST_QSCAN;
                end
                hhst_pkg::ST_QSCAN: begin
                    if (rd_ok_reg && q_own_rd == p_idx_reg && q_val_rd == port_reg) begin
                        state_reg <= hhst_pkg::ST_WB;
                    end else if (idx_reg >= q_fill_reg && !rd_ok_reg) begin
                        if (q_fill_reg >= (QW+1)'(hhst_pkg::MAX_PORT_ENTRIES)) begin
                            ovf_reg <= hhst_pkg::OVF_PORT;
                            state_reg <= hhst_pkg::ST_WB;
                        end else begin
                            state_reg <= hhst_pkg::ST_QUPD;
                        end
                    end else begin
                        rd_idx_prev_reg <= idx_reg;
                        rd_ok_reg <= (idx_reg < q_fill_reg);
                        if (idx_reg < q_fill_reg) idx_reg <= idx_reg + 1'b1;
                    end
                end
                hhst_pkg::ST_QUPD: begin
                    logic [10:0] c;
                    c = (cnt_reg < hhst_pkg::COUNT_MAX) ? cnt_reg + 11'd1 : cnt_reg;
                    q_own_mem[q_fill_reg[QW-1:0]] <= p_idx_reg;
                    q_val_mem[q_fill_reg[QW-1:0]] <= port_reg;
                    q_fill_reg <= q_fill_reg + 1'b1;
                    cnt_reg <= c;
                    if ({5'd0, c} >= scan_thr_reg && !pmark_reg) begin
                        pmark_reg <= 1'b1;
                        pstamp_reg <= now_reg;
                    end
                    state_reg <= hhst_pkg::ST_WB;
                end
                hhst_pkg::ST_WB: begin
                    p_own_mem[p_idx_reg] <= s_idx_reg;
                    p_dst_mem[p_idx_reg] <= dst_reg;
                    p_cnt_mem[p_idx_reg] <= cnt_reg;
                    p_mark_mem[p_idx_reg] <= pmark_reg;
                    p_stamp_mem[p_idx_reg] <= pstamp_reg;
                    state_reg <= hhst_pkg::ST_OUT;
                end
                hhst_pkg::ST_OUT: begin
                    if (m_tready) state_reg <= hhst_pkg::ST_IDLE;
                end
                default: state_reg <= hhst_pkg::ST_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

### design/hhst_checker.sv
`default_nettype none
module hhst_checker (
    input wire logic         aclk,
    input wire logic         aresetn,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [111:0] m_tdata
);
    // never take a new item while a result is pending
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("ready while result pending");
    // accepted item is in progress next cycle
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !s_tready) else $error("ready after accept");
    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result dropped");
    // source overflow zeros all other fields
    a_ovf: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[110:109] == 2'd1) |-> (m_tdata[108:0] == '0))
        else $error("overflow fields not zero");
endmodule
bind heavy_hitter_scan_tracker hhst_checker u_chk (
    .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata));
`default_nettype wire
